FILE: hw/rtl/gb3_pkg.sv
// Shared types and constants of the 3x3 Gaussian blur.
package gb3_pkg;

  localparam int PIXEL_W = 8;
  localparam int COORD_W = 10;
  localparam int CFG_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int SUM_W = 12;
  localparam int MIN_SIZE = 3;
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;
  localparam int OUT_DEPTH = 4;

  localparam logic [CFG_W-1:0] RESET_WIDTH = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  // Per-item control carried from the counter stage to the window stage.
  typedef struct packed {
    logic               has_result;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               last;
  } tag_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] blurred;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               last;
  } result_t;

endpackage

FILE: hw/rtl/gb3_line_store.sv
// Line store memory holding the two previous rows, one word per column.
module gb3_line_store #(
  parameter int MAX_WIDTH = gb3_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [gb3_pkg::PIXEL_W-1:0] rd_upper,
  output logic [gb3_pkg::PIXEL_W-1:0] rd_middle,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [gb3_pkg::PIXEL_W-1:0] wr_upper,
  input  logic [gb3_pkg::PIXEL_W-1:0] wr_middle
);
  import gb3_pkg::*;

  logic [2*PIXEL_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_upper, wr_middle};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_upper, rd_middle} <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/gb3_window.sv
// Six-pixel window and the 1-2-1 by 1-2-1 weighted sum.
module gb3_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [gb3_pkg::PIXEL_W-1:0] top,
  input  logic [gb3_pkg::PIXEL_W-1:0] mid,
  input  logic [gb3_pkg::PIXEL_W-1:0] bot,
  input  gb3_pkg::tag_t               tag,
  output logic                        push,
  output gb3_pkg::result_t            result
);
  import gb3_pkg::*;

  // Entries 0..2 hold column c-2 (top, middle, bottom), entries 3..5 column c-1.
  logic [PIXEL_W-1:0] win [6];
  logic [SUM_W-1:0]   sum;

  always_comb begin
    sum = SUM_W'(win[0]) + (SUM_W'(win[3]) << 1) + SUM_W'(top)
        + (SUM_W'(win[1]) << 1) + (SUM_W'(win[4]) << 2) + (SUM_W'(mid) << 1)
        + SUM_W'(win[2]) + (SUM_W'(win[5]) << 1) + SUM_W'(bot);
  end

  assign push = step && tag.has_result;
  assign result.blurred = sum[SUM_W-1:SUM_W-PIXEL_W];
  assign result.row = tag.row;
  assign result.column = tag.column;
  assign result.last = tag.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (step) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
    end
  end

endmodule

FILE: hw/rtl/gb3_out_fifo.sv
// Small result queue between the window stage and the output channel.
module gb3_out_fifo #(
  parameter int DEPTH = gb3_pkg::OUT_DEPTH,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gb3_pkg::result_t push_data,
  input  logic             pop,
  output logic             not_empty,
  output gb3_pkg::result_t head,
  output logic [CNT_W-1:0] count
);
  import gb3_pkg::*;

  localparam int PW = $clog2(DEPTH);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;

  assign not_empty = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/gaussian_blur_3x3.sv
// Top level of the 3x3 Gaussian blur over a raster pixel stream.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | pixel_in
//  output   | out_valid / out_ready | blurred, out_row, out_column, frame_last
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One pixel item is taken per clock while in_ready is high; the line store is
// read when an item is taken and written back the next cycle.
// The small result queue keeps input flowing while an output item waits.
// Reset clears the counts, window and queue and loads a 640 by 480 frame.
// Input stalls only when the result queue would otherwise overflow.
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH = gb3_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = gb3_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gb3_pkg::PIXEL_W-1:0]     pixel_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gb3_pkg::PIXEL_W-1:0]     blurred,
  output logic [gb3_pkg::COORD_W-1:0]     out_row,
  output logic [gb3_pkg::COORD_W-1:0]     out_column,
  output logic                            frame_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gb3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gb3_pkg::CFG_W-1:0]       cfg_data
);
  import gb3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW0 = (CW > RW) ? CW + 1 : RW + 1;
  localparam int SW = (SW0 > CFG_W) ? SW0 : CFG_W;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int PEND_W = CNT_W + 1;

  // Effective size minus one after clamping to the legal range.
  function automatic logic [SW-1:0] size_last(input logic [CFG_W-1:0] v,
                                              input logic [SW-1:0] max_size);
    logic [SW-1:0] ext;
    logic [SW-1:0] eff;
    ext = SW'(v);
    if (ext < SW'(MIN_SIZE)) begin
      eff = SW'(MIN_SIZE);
    end else if (ext > max_size) begin
      eff = max_size;
    end else begin
      eff = ext;
    end
    return eff - 1'b1;
  endfunction

  logic [CW-1:0] width_last;
  logic [RW-1:0] height_last;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [SW-1:0] new_last;

  logic          accept;
  logic          cfg_write;
  logic          s1_valid;
  logic [CW-1:0] s1_col;
  logic [PIXEL_W-1:0] s1_pixel;
  tag_t          s1_tag;
  tag_t          tag_next;

  logic [PIXEL_W-1:0] rd_upper;
  logic [PIXEL_W-1:0] rd_middle;
  logic          push;
  result_t       push_data;
  result_t       head;
  logic [CNT_W-1:0] fifo_count;
  logic [PEND_W-1:0] pending;
  logic          pop;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign pending = PEND_W'(fifo_count) + PEND_W'(s1_valid);
  assign in_ready = (pending < PEND_W'(OUT_DEPTH));
  assign accept = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_comb begin
    tag_next.has_result = (row >= RW'(2)) && (col >= CW'(2));
    tag_next.row = COORD_W'(row - 1'b1);
    tag_next.column = COORD_W'(col - 1'b1);
    tag_next.last = (row == height_last) && (col == width_last);
  end

  always_comb begin
    case (cfg_index)
      REG_IMAGE_WIDTH:  new_last = size_last(cfg_data, SW'(MAX_WIDTH));
      REG_IMAGE_HEIGHT: new_last = size_last(cfg_data, SW'(MAX_HEIGHT));
      default:          new_last = '0;
    endcase
  end

  // Sizes and raster counts; a write to the width or height register restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_last <= CW'(size_last(RESET_WIDTH, SW'(MAX_WIDTH)));
      height_last <= RW'(size_last(RESET_HEIGHT, SW'(MAX_HEIGHT)));
      col <= '0;
      row <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_last <= new_last[CW-1:0];
          col <= '0;
          row <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_last <= new_last[RW-1:0];
          col <= '0;
          row <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col == width_last) begin
        col <= '0;
        row <= (row == height_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col <= col;
      s1_pixel <= pixel_in;
      s1_tag <= tag_next;
    end
  end

  gb3_line_store #(
    .MAX_WIDTH(MAX_WIDTH),
    .AW(CW)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (accept),
    .rd_addr  (col),
    .rd_upper (rd_upper),
    .rd_middle(rd_middle),
    .wr_en    (s1_valid),
    .wr_addr  (s1_col),
    .wr_upper (rd_middle),
    .wr_middle(s1_pixel)
  );

  gb3_window u_window (
    .clk   (clk),
    .rst   (rst),
    .step  (s1_valid),
    .top   (rd_upper),
    .mid   (rd_middle),
    .bot   (s1_pixel),
    .tag   (s1_tag),
    .push  (push),
    .result(push_data)
  );

  gb3_out_fifo #(
    .DEPTH(OUT_DEPTH),
    .CNT_W(CNT_W)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .not_empty(out_valid),
    .head     (head),
    .count    (fifo_count)
  );

  assign blurred = head.blurred;
  assign out_row = head.row;
  assign out_column = head.column;
  assign frame_last = head.last;

  // A new read never targets the column being written back this cycle.
  a_no_addr_clash: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_valid) |-> (col != s1_col))
    else $error("line store read and write collide");

  // Items in the queue plus the one in flight never exceed its depth.
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(OUT_DEPTH))
    else $error("result queue overflow");

  // The frame-end mark only ever rides on an item that gives a result.
  a_last_has_result: assert property (@(posedge clk) disable iff (rst)
    (accept && tag_next.last) |=> (s1_tag.has_result && push))
    else $error("frame end mark without a result");

endmodule

FILE: verif/tb_gaussian_blur_3x3.sv
// Self-checking testbench for the 3x3 Gaussian blur over a raster pixel stream.
`timescale 1ns / 100ps

module tb_gaussian_blur_3x3;
  import gb3_pkg::*;

  localparam int CLK_PERIOD = 2;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_CAP = 120;
  localparam int CALM_ITEMS = 200;
  localparam int RESET_ITEMS = 2 * RESET_WIDTH + 4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct {
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_W-1:0]       data;
  } reg_write_t;

  // Mirrors the line stores, the window and the frame counts, and keeps the
  // blurred pixels that are still owed by the block.
  class blur_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col;
    int unsigned      row;
    pixel_t           upper_line[DEFAULT_MAX_WIDTH];
    pixel_t           middle_line[DEFAULT_MAX_WIDTH];
    pixel_t           win[6];
    result_t          pending_blurs[$];
    int unsigned      errors;

    function new();
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      col = 0;
      row = 0;
      errors = 0;
      foreach (upper_line[k]) begin
        upper_line[k] = '0;
        middle_line[k] = '0;
      end
      foreach (win[k]) win[k] = '0;
    endfunction

    function int unsigned fit_size(logic [CFG_W-1:0] v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return fit_size(width_reg, DEFAULT_MAX_WIDTH) * fit_size(height_reg, DEFAULT_MAX_HEIGHT);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_IMAGE_WIDTH: begin
          width_reg = data;
          col = 0;
          row = 0;
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data;
          col = 0;
          row = 0;
        end
        default: ;
      endcase
    endfunction

    function void blur_pixel(pixel_t p);
      int unsigned w;
      int unsigned h;
      int unsigned sum;
      pixel_t      top;
      pixel_t      mid;
      result_t     res;
      w = fit_size(width_reg, DEFAULT_MAX_WIDTH);
      h = fit_size(height_reg, DEFAULT_MAX_HEIGHT);
      top = upper_line[col];
      mid = middle_line[col];
      upper_line[col] = mid;
      middle_line[col] = p;
      if (row >= 2 && col >= 2) begin
        sum = win[0] + 2 * win[3] + top + 2 * win[1] + 4 * win[4] + 2 * mid +
              win[2] + 2 * win[5] + p;
        res.blurred = PIXEL_W'(sum >> 4);
        res.row = COORD_W'(row - 1);
        res.column = COORD_W'(col - 1);
        res.last = (row == h - 1) && (col == w - 1);
        pending_blurs.push_back(res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = p;
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_blur(pixel_t blurred, logic [COORD_W-1:0] out_row,
                             logic [COORD_W-1:0] out_column, logic frame_last);
      result_t want;
      if (pending_blurs.size() == 0) begin
        $error("unexpected result: blurred %0d row %0d column %0d frame_last %0d",
               blurred, out_row, out_column, frame_last);
        errors++;
        return;
      end
      want = pending_blurs.pop_front();
      if (blurred !== want.blurred) begin
        $error("blurred: expected %0d, actual %0d", want.blurred, blurred);
        errors++;
      end
      if (out_row !== want.row) begin
        $error("out_row: expected %0d, actual %0d", want.row, out_row);
        errors++;
      end
      if (out_column !== want.column) begin
        $error("out_column: expected %0d, actual %0d", want.column, out_column);
        errors++;
      end
      if (frame_last !== want.last) begin
        $error("frame_last: expected %0d, actual %0d", want.last, frame_last);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  pixel_t                 pixel_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  pixel_t                 blurred;
  logic [COORD_W-1:0]     out_row;
  logic [COORD_W-1:0]     out_column;
  logic                   frame_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  blur_scoreboard sb;
  reg_write_t     reg_writes[$];
  bit             calm = 1'b0;
  bit             hold_ask = 1'b0;
  int unsigned    quiet_cycles = 0;

  gaussian_blur_3x3 i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .blurred   (blurred),
    .out_row   (out_row),
    .out_column(out_column),
    .frame_last(frame_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic pixel_t random_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIXEL_W'($urandom_range(255));
    endcase
  endfunction

  // Mostly small frames, with the clamped ranges at either end now and then.
  function automatic logic [CFG_W-1:0] random_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return CFG_W'($urandom_range(2));
    if (pick < 15) return CFG_W'($urandom_range(2047, 1025));
    if (pick < 22) return CFG_W'($urandom_range(64, 17));
    return CFG_W'($urandom_range(12, 3));
  endfunction

  task automatic send_pixel(input pixel_t p);
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 21);
    end
    in_valid <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
    sb.blur_pixel(p);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic program_regs();
    foreach (reg_writes[k]) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_writes[k].index;
      cfg_data <= reg_writes[k].data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(reg_writes[k].index, reg_writes[k].data);
    end
    cfg_valid <= 1'b0;
    reg_writes.delete();
  endtask

  // Stop offering pixels, collect every owed result, then let the pipeline
  // empty of items that produce nothing.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.pending_blurs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_sized(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int unsigned count);
    reg_writes.push_back('{REG_IMAGE_WIDTH, w});
    reg_writes.push_back('{REG_IMAGE_HEIGHT, h});
    program_regs();
    send_random(count);
    finish_phase();
  endtask

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_blur(blurred, out_row, out_column, frame_last);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_gaussian_blur_3x3: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned random_items;
    int unsigned count;
    int unsigned frame;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // The reset frame size: just enough to see the first few results.
    send_random(RESET_ITEMS);
    finish_phase();

    // Undersized registers fall back to the minimum frame; three frames in a
    // row also cover the wrap at the end of each.
    reg_writes.push_back('{REG_IMAGE_WIDTH, CFG_W'(0)});
    reg_writes.push_back('{REG_IMAGE_HEIGHT, CFG_W'(2)});
    reg_writes.push_back('{REG_SPARE, CFG_W'(2047)});
    program_regs();
    repeat (9) send_pixel('1);
    repeat (9) send_pixel('0);
    for (int k = 0; k < 9; k++) send_pixel((k == 4) ? '1 : '0);
    finish_phase();

    // Tall narrow frame with a long output stall, so that the block backs up.
    reg_writes.push_back('{REG_IMAGE_WIDTH, CFG_W'(3)});
    reg_writes.push_back('{REG_IMAGE_HEIGHT, CFG_W'(200)});
    program_regs();
    hold_ask = 1'b1;
    send_random(PHASE_CAP);
    finish_phase();
    random_items = RESET_ITEMS + 3 * 9 + PHASE_CAP;

    while (random_items + CALM_ITEMS < RANDOM_ITEMS) begin
      if ($urandom_range(3) != 0) reg_writes.push_back('{REG_IMAGE_WIDTH, random_size()});
      if ($urandom_range(3) != 0) reg_writes.push_back('{REG_IMAGE_HEIGHT, random_size()});
      if ($urandom_range(9) == 0) begin
        reg_writes.push_back('{REG_SPARE, CFG_W'($urandom_range(2047))});
      end
      program_regs();
      frame = sb.frame_pixels();
      // Mostly one or two whole random frames and maybe a part; or a cut frame.
      if ($urandom_range(3) == 0) begin
        count = $urandom_range(frame, 1);
      end else begin
        count = frame * $urandom_range(2, 1) + ($urandom_range(1) ? $urandom_range(frame - 1) : 0);
      end
      if (count > PHASE_CAP) count = PHASE_CAP;
      send_random(count);
      finish_phase();
      random_items += count;
    end

    // A stretch with no idling on either side, with an oversized height.
    calm = 1'b1;
    run_sized(CFG_W'(12), CFG_W'(2047), CALM_ITEMS);
    calm = 1'b0;

    if (sb.errors == 0 && sb.pending_blurs.size() == 0) begin
      $display("tb_gaussian_blur_3x3: clean");
    end else begin
      $display("tb_gaussian_blur_3x3: errors");
    end
    $finish;
  end

endmodule
